### hdl/palette_error_diffusion_dither_assert.svh
// ----------------------------------------------------------------------------
// Palette dither assertion macros
// Concurrent assertion wrappers clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PALETTE_ERROR_DIFFUSION_DITHER_ASSERT_SVH
`define PALETTE_ERROR_DIFFUSION_DITHER_ASSERT_SVH
`ifndef ASSERT_OFF
`define PED_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("palette dither assertion failed");
`define PED_NEVER(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("palette dither forbidden condition");
`else
`define PED_ASSERT(label, prop)
`define PED_NEVER(label, expr)
`endif
`endif

### hdl/ped_pkg.sv
// ----------------------------------------------------------------------------
// Palette dither package
// Shared constants, codes and types of the palette error-diffusion dither.
// ----------------------------------------------------------------------------
`default_nettype none
package ped_pkg;
   localparam int MAX_WIDTH     = 1024;
   localparam int COL_W         = $clog2(MAX_WIDTH);
   localparam int PALETTE_DEPTH = 256;
   localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
   localparam int QUEUE_DEPTH   = 2;
   localparam int NUM_TARGETS   = 6;

   localparam int METHOD_W  = 2;
   localparam int WIDTH_W   = 11;
   localparam int HEIGHT_W  = 16;
   localparam int ENTRIES_W = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [METHOD_W-1:0] METHOD_NONE     = 2'd0;
   localparam logic [METHOD_W-1:0] METHOD_FLOYD    = 2'd1;
   localparam logic [METHOD_W-1:0] METHOD_ATKINSON = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_METHOD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ENTRIES = 2'd3;

   typedef enum logic {KIND_LOAD, KIND_PIXEL} kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  entry;
      logic [31:0] color;
   } item_type;

   typedef struct packed {
      logic [METHOD_W-1:0]  method;
      logic [WIDTH_W-1:0]   width;
      logic [HEIGHT_W-1:0]  height;
      logic [ENTRIES_W-1:0] entries;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_ADD, ST_SEARCH, ST_ERR, ST_TARGET, ST_WRITE, ST_FINISH
   } state_type;
endpackage
`default_nettype wire

### hdl/ped_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying palette loads and pixels.
// ----------------------------------------------------------------------------
`default_nettype none
interface ped_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] entry_number;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha;
   modport source (output valid, operation, entry_number, red, green, blue, alpha,
                   input ready);
   modport sink (input valid, operation, entry_number, red, green, blue, alpha,
                 output ready);
endinterface
`default_nettype wire

### hdl/ped_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one palette index per pixel.
// ----------------------------------------------------------------------------
`default_nettype none
interface ped_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] chosen_index;
   logic       row_end;
   logic       image_end;
   modport source (output valid, chosen_index, row_end, image_end, input ready);
   modport sink (input valid, chosen_index, row_end, image_end, output ready);
endinterface
`default_nettype wire

### hdl/palette_error_diffusion_dither.sv
// ----------------------------------------------------------------------------
// Palette error-diffusion dither
// Maps RGBA pixels in raster order to palette indices with error diffusion.
// ----------------------------------------------------------------------------
// A palette load is written to the palette memory from the idle state of the
// back end. For a pixel, one shared distance unit visits the palette entries
// in use, one palette entry per cycle, followed by up to six
// read-modify-write updates of the line error memories. At each row end a
// pass over all 1024 addresses clears the line buffer that becomes the row two
// ahead; at image end and after reset the same pass clears all three line
// buffers, during which no new item is started. The front and a two-entry
// queue keep taking transfers while the back end works, until the queue is full.
`default_nettype none
module palette_error_diffusion_dither (
   input  wire logic                            clock,
   input  wire logic                            reset,
   ped_req_if.sink                              req_bus,
   ped_rsp_if.source                            rsp_bus,
   input  wire logic                            csr_we,
   input  wire logic [ped_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ped_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   ped_pkg::cfg_type  cfg_ff, cfg_in;
   logic              f_valid, f_ready, q_valid, q_pop;
   ped_pkg::item_type f_item, q_item;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            ped_pkg::REG_METHOD:  cfg_in.method  = csr_wdata[ped_pkg::METHOD_W-1:0];
            ped_pkg::REG_WIDTH:   cfg_in.width   = csr_wdata[ped_pkg::WIDTH_W-1:0];
            ped_pkg::REG_HEIGHT:  cfg_in.height  = csr_wdata[ped_pkg::HEIGHT_W-1:0];
            ped_pkg::REG_ENTRIES: cfg_in.entries = csr_wdata[ped_pkg::ENTRIES_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.method  <= ped_pkg::METHOD_FLOYD;
         cfg_ff.width   <= ped_pkg::WIDTH_W'(1024);
         cfg_ff.height  <= ped_pkg::HEIGHT_W'(768);
         cfg_ff.entries <= ped_pkg::ENTRIES_W'(256);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ped_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_item  (f_item)
   );

   ped_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_item   (f_item),
      .out_valid (q_valid),
      .out_ready (q_pop),
      .out_item  (q_item)
   );

   ped_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_valid (q_valid),
      .q_pop   (q_pop),
      .q_item  (q_item),
      .rsp_bus (rsp_bus)
   );
endmodule
`default_nettype wire

### hdl/ped_queue.sv
// ----------------------------------------------------------------------------
// Palette dither item queue
// Short queue between the front and the back of the dither.
// ----------------------------------------------------------------------------
`default_nettype none
module ped_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output      logic              in_ready,
   input  wire ped_pkg::item_type in_item,
   output      logic              out_valid,
   input  wire logic              out_ready,
   output      ped_pkg::item_type out_item
);
   localparam int PTR_W = $clog2(ped_pkg::QUEUE_DEPTH);

   ped_pkg::item_type          slot_ff [ped_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]             count_ff, count_in;
   logic                       push, pop;

   always_comb begin
      in_ready  = count_ff != (PTR_W+1)'(ped_pkg::QUEUE_DEPTH);
      out_valid = count_ff != '0;
      out_item  = slot_ff[rd_ptr_ff];
      push      = in_valid && in_ready;
      pop       = out_valid && out_ready;
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule
`default_nettype wire

### hdl/ped_front.sv
// ----------------------------------------------------------------------------
// Palette dither front
// Accepts request transfers and classifies them as palette loads or pixels.
// ----------------------------------------------------------------------------
`default_nettype none
module ped_front (
   input  wire logic              clock,
   input  wire logic              reset,
   ped_req_if.sink                req_bus,
   output      logic              out_valid,
   input  wire logic              out_ready,
   output      ped_pkg::item_type out_item
);
   logic              valid_ff, valid_in;
   ped_pkg::item_type item_ff, item_in;
   logic              take;

   always_comb begin
      req_bus.ready = !valid_ff || out_ready;
      take          = req_bus.valid && req_bus.ready;
      out_valid     = valid_ff;
      out_item      = item_ff;
      item_in.kind  = req_bus.operation ? ped_pkg::KIND_PIXEL : ped_pkg::KIND_LOAD;
      item_in.entry = req_bus.entry_number;
      item_in.color = {req_bus.alpha, req_bus.blue, req_bus.green, req_bus.red};
      valid_in      = take || (valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end
endmodule
`default_nettype wire

### hdl/ped_back.sv
// ----------------------------------------------------------------------------
// Palette dither back
// Runs palette loads, the nearest-entry search and the error diffusion.
// ----------------------------------------------------------------------------
`default_nettype none
`include "palette_error_diffusion_dither_assert.svh"
module ped_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ped_pkg::cfg_type  cfg,
   input  wire logic              q_valid,
   output      logic              q_pop,
   input  wire ped_pkg::item_type q_item,
   ped_rsp_if.source              rsp_bus
);
   localparam int CW = ped_pkg::COL_W;
   localparam int WW = ped_pkg::WIDTH_W;
   localparam int HW = ped_pkg::HEIGHT_W;
   localparam int NW = ped_pkg::ENTRIES_W;

   ped_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      clr_cnt_ff, clr_cnt_in;
   logic [2:0]         clr_mask_ff, clr_mask_in;
   logic [1:0]         cur_ff, cur_in;
   logic [CW-1:0]      col_cnt_ff, col_cnt_in;
   logic [HW-1:0]      row_cnt_ff, row_cnt_in;
   logic [31:0]        pix_ff, pix_in;
   logic [12:0]        col_ff [4];
   logic [12:0]        col_in [4];
   logic [NW-1:0]      iss_ff, iss_in;
   logic               v1_ff, v1_in, v2_ff, v2_in;
   logic [7:0]         idx1_ff, idx1_in, idx2_ff, idx2_in;
   logic [23:0]        sq_ff [4];
   logic [23:0]        sq_in [4];
   logic [31:0]        pal2_ff, pal2_in;
   logic [25:0]        bestd_ff, bestd_in;
   logic [7:0]         best_idx_ff, best_idx_in;
   logic [31:0]        best_pal_ff, best_pal_in;
   logic signed [13:0] err_ff [4];
   logic signed [13:0] err_in [4];
   logic [2:0]         tgt_ff, tgt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_index_ff;
   logic               rsp_row_ff, rsp_image_ff;
   logic               rsp_load;

   logic [31:0]        pal_mem [ped_pkg::PALETTE_DEPTH];
   logic [31:0]        pal_q;
   logic               pal_we;
   logic [63:0]        row_q [3];
   logic [2:0]         mem_we;
   logic [CW-1:0]      mem_waddr, mem_raddr;
   logic [63:0]        mem_wdata;

   logic [WW-1:0]      w_eff;
   logic [HW-1:0]      h_eff;
   logic [NW-1:0]      n_eff;
   logic               last_col, last_row, x1lt, x2lt, row2lt;
   logic [1:0]         nxt_ptr, aft_ptr;
   logic               tgt_en, tgt_sh4;
   logic [2:0]         tgt_num;
   logic [1:0]         tgt_sel;
   logic [CW-1:0]      tgt_addr;
   logic [25:0]        dsum;
   logic [63:0]        upd;
   logic               floyd, atk;

   function automatic logic [15:0] sat16(input logic signed [16:0] v);
      logic [15:0] r;
      if (v > 17'sd32767) begin
         r = 16'h7fff;
      end else if (v < -17'sd32768) begin
         r = 16'h8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (pal_we) begin
         pal_mem[q_item.entry] <= q_item.color;
      end
      pal_q <= pal_mem[iss_ff[ped_pkg::PAL_AW-1:0]];
   end

   for (genvar g = 0; g < 3; g++) begin : g_row
      logic [63:0] row_mem [ped_pkg::MAX_WIDTH];
      always_ff @(posedge clock) begin
         if (mem_we[g]) begin
            row_mem[mem_waddr] <= mem_wdata;
         end
         row_q[g] <= row_mem[mem_raddr];
      end
   end

   always_comb begin
      w_eff = (cfg.width == '0) ? WW'(1) :
              (cfg.width > WW'(ped_pkg::MAX_WIDTH)) ? WW'(ped_pkg::MAX_WIDTH) : cfg.width;
      h_eff = (cfg.height == '0) ? HW'(1) : cfg.height;
      n_eff = (cfg.entries == '0) ? NW'(1) :
              (cfg.entries > NW'(ped_pkg::PALETTE_DEPTH)) ? NW'(ped_pkg::PALETTE_DEPTH)
                                                         : cfg.entries;
      last_col = ({1'b0, col_cnt_ff} + WW'(1)) >= w_eff;
      x1lt     = ({1'b0, col_cnt_ff} + WW'(1)) < w_eff;
      x2lt     = ({1'b0, col_cnt_ff} + WW'(2)) < w_eff;
      last_row = ({1'b0, row_cnt_ff} + (HW+1)'(1)) >= {1'b0, h_eff};
      row2lt   = ({1'b0, row_cnt_ff} + (HW+1)'(2)) < {1'b0, h_eff};
      nxt_ptr  = (cur_ff == 2'd2) ? 2'd0 : cur_ff + 2'd1;
      aft_ptr  = (cur_ff == 2'd0) ? 2'd2 : cur_ff - 2'd1;
      floyd    = cfg.method == ped_pkg::METHOD_FLOYD;
      atk      = cfg.method == ped_pkg::METHOD_ATKINSON;
      tgt_num  = 3'd1;
      tgt_sh4  = !atk;
      unique case (tgt_ff)
         3'd0: begin
            tgt_en = (floyd || atk) && x1lt; tgt_sel = cur_ff;
            tgt_addr = col_cnt_ff + CW'(1); tgt_num = atk ? 3'd1 : 3'd7;
         end
         3'd1: begin
            tgt_en = (floyd || atk) && !last_row && (col_cnt_ff != '0);
            tgt_sel = nxt_ptr; tgt_addr = col_cnt_ff - CW'(1);
            tgt_num = atk ? 3'd1 : 3'd3;
         end
         3'd2: begin
            tgt_en = (floyd || atk) && !last_row; tgt_sel = nxt_ptr;
            tgt_addr = col_cnt_ff; tgt_num = atk ? 3'd1 : 3'd5;
         end
         3'd3: begin
            tgt_en = (floyd || atk) && !last_row && x1lt; tgt_sel = nxt_ptr;
            tgt_addr = col_cnt_ff + CW'(1);
         end
         3'd4: begin
            tgt_en = atk && x2lt; tgt_sel = cur_ff; tgt_addr = col_cnt_ff + CW'(2);
         end
         3'd5: begin
            tgt_en = atk && !last_row && row2lt; tgt_sel = aft_ptr;
            tgt_addr = col_cnt_ff;
         end
         default: begin
            tgt_en = 1'b0; tgt_sel = cur_ff; tgt_addr = col_cnt_ff;
         end
      endcase
   end

   always_comb begin
      logic signed [13:0] diff;
      logic signed [17:0] v;
      logic [12:0]        mag, q;
      logic [15:0]        prod;
      logic signed [16:0] s;
      logic signed [16:0] sum;
      state_in    = state_ff;
      clr_cnt_in  = clr_cnt_ff;
      clr_mask_in = clr_mask_ff;
      cur_in      = cur_ff;
      col_cnt_in  = col_cnt_ff;
      row_cnt_in  = row_cnt_ff;
      pix_in      = pix_ff;
      iss_in      = iss_ff;
      v1_in       = 1'b0;
      v2_in       = 1'b0;
      idx1_in     = idx1_ff;
      idx2_in     = idx2_ff;
      pal2_in     = pal2_ff;
      bestd_in    = bestd_ff;
      best_idx_in = best_idx_ff;
      best_pal_in = best_pal_ff;
      tgt_in      = tgt_ff;
      rsp_load    = 1'b0;
      q_pop       = 1'b0;
      pal_we      = 1'b0;
      mem_we      = '0;
      mem_waddr   = clr_cnt_ff;
      mem_wdata   = '0;
      mem_raddr   = col_cnt_ff;
      dsum = 26'(sq_ff[0]) + 26'(sq_ff[1]) + 26'(sq_ff[2]) + 26'(sq_ff[3]);
      for (int c = 0; c < 4; c++) begin
         v = 18'($signed({1'b0, pix_ff[8*c +: 8], 4'b0000}))
             + 18'($signed(row_q[cur_ff][16*c +: 16]));
         col_in[c] = (v < 18'sd0) ? 13'd0 : (v > 18'sd4080) ? 13'd4080 : v[12:0];
         diff = $signed({1'b0, col_ff[c]}) - $signed({2'b00, pal_q[8*c +: 8], 4'b0000});
         sq_in[c] = 24'(diff * diff);
         err_in[c] = $signed({1'b0, col_ff[c]})
                     - $signed({2'b00, best_pal_ff[8*c +: 8], 4'b0000});
         mag  = err_ff[c][13] ? 13'(-err_ff[c]) : err_ff[c][12:0];
         prod = 16'(mag * tgt_num);
         q    = tgt_sh4 ? {1'b0, prod[15:4]} : prod[15:3];
         s    = err_ff[c][13] ? -$signed({4'b0000, q}) : $signed({4'b0000, q});
         sum  = 17'($signed(row_q[tgt_sel][16*c +: 16])) + s;
         upd[16*c +: 16] = sat16(sum);
      end
      unique case (state_ff)
         ped_pkg::ST_CLEAR: begin
            mem_we     = clr_mask_ff;
            clr_cnt_in = clr_cnt_ff + CW'(1);
            if (clr_cnt_ff == CW'(ped_pkg::MAX_WIDTH - 1)) begin
               state_in = ped_pkg::ST_IDLE;
            end
         end
         ped_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               pix_in = q_item.color;
               if (q_item.kind == ped_pkg::KIND_LOAD) begin
                  pal_we = 1'b1;
               end else begin
                  state_in = ped_pkg::ST_ADD;
               end
            end
         end
         ped_pkg::ST_ADD: begin
            iss_in      = '0;
            bestd_in    = '1;
            best_idx_in = '0;
            state_in    = ped_pkg::ST_SEARCH;
         end
         ped_pkg::ST_SEARCH: begin
            if (iss_ff < n_eff) begin
               v1_in   = 1'b1;
               idx1_in = iss_ff[7:0];
               iss_in  = iss_ff + NW'(1);
            end
            v2_in   = v1_ff;
            idx2_in = idx1_ff;
            pal2_in = pal_q;
            if (v2_ff && dsum < bestd_ff) begin
               bestd_in    = dsum;
               best_idx_in = idx2_ff;
               best_pal_in = pal2_ff;
            end
            if (iss_ff == n_eff && !v1_ff && !v2_ff) begin
               state_in = ped_pkg::ST_ERR;
            end
         end
         ped_pkg::ST_ERR: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load = 1'b1;
               tgt_in   = '0;
               state_in = ped_pkg::ST_TARGET;
            end
         end
         ped_pkg::ST_TARGET: begin
            mem_raddr = tgt_addr;
            if (tgt_en) begin
               state_in = ped_pkg::ST_WRITE;
            end else begin
               tgt_in = tgt_ff + 3'd1;
               if (tgt_ff == 3'(ped_pkg::NUM_TARGETS - 1)) begin
                  state_in = ped_pkg::ST_FINISH;
               end
            end
         end
         ped_pkg::ST_WRITE: begin
            mem_we[tgt_sel] = 1'b1;
            mem_waddr       = tgt_addr;
            mem_wdata       = upd;
            tgt_in          = tgt_ff + 3'd1;
            if (tgt_ff == 3'(ped_pkg::NUM_TARGETS - 1)) begin
               state_in = ped_pkg::ST_FINISH;
            end else begin
               state_in = ped_pkg::ST_TARGET;
            end
         end
         ped_pkg::ST_FINISH: begin
            state_in = ped_pkg::ST_IDLE;
            if (last_col) begin
               col_cnt_in = '0;
               clr_cnt_in = '0;
               state_in   = ped_pkg::ST_CLEAR;
               if (last_row) begin
                  row_cnt_in  = '0;
                  cur_in      = 2'd0;
                  clr_mask_in = 3'b111;
               end else begin
                  row_cnt_in          = row_cnt_ff + HW'(1);
                  cur_in              = nxt_ptr;
                  clr_mask_in         = '0;
                  clr_mask_in[cur_ff] = 1'b1;
               end
            end else begin
               col_cnt_in = col_cnt_ff + CW'(1);
            end
         end
      endcase
      rsp_valid_in   = rsp_load || (rsp_valid_ff && !rsp_bus.ready);
      rsp_bus.valid        = rsp_valid_ff;
      rsp_bus.chosen_index = rsp_index_ff;
      rsp_bus.row_end      = rsp_row_ff;
      rsp_bus.image_end    = rsp_image_ff;
   end

   always_ff @(posedge clock) begin
      pix_ff      <= pix_in;
      col_ff      <= (state_ff == ped_pkg::ST_ADD) ? col_in : col_ff;
      iss_ff      <= iss_in;
      idx1_ff     <= idx1_in;
      idx2_ff     <= idx2_in;
      sq_ff       <= sq_in;
      pal2_ff     <= pal2_in;
      bestd_ff    <= bestd_in;
      best_idx_ff <= best_idx_in;
      best_pal_ff <= best_pal_in;
      err_ff      <= (state_ff == ped_pkg::ST_ERR) ? err_in : err_ff;
      tgt_ff      <= tgt_in;
      if (rsp_load) begin
         rsp_index_ff <= best_idx_ff;
         rsp_row_ff   <= last_col;
         rsp_image_ff <= last_col && last_row;
      end
      if (reset) begin
         state_ff     <= ped_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         clr_mask_ff  <= 3'b111;
         cur_ff       <= 2'd0;
         col_cnt_ff   <= '0;
         row_cnt_ff   <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_mask_ff  <= clr_mask_in;
         cur_ff       <= cur_in;
         col_cnt_ff   <= col_cnt_in;
         row_cnt_ff   <= row_cnt_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `PED_ASSERT(a_stage2_follows_stage1, v2_ff |-> $past(v1_ff))
   `PED_NEVER(a_row_pointer_range, cur_ff == 2'd3)
   `PED_ASSERT(a_best_within_palette, (state_ff == ped_pkg::ST_ERR) |-> ({1'b0, best_idx_ff} < n_eff))
   `PED_ASSERT(a_result_from_error_step, $rose(rsp_valid_ff) |-> ($past(state_ff) == ped_pkg::ST_ERR))
endmodule
`default_nettype wire

### verif/palette_error_diffusion_dither_tb.sv
// ----------------------------------------------------------------------------
// Palette error-diffusion dither testbench
// Loads a palette and streams pixels through several image sizes, search
// depths and diffusion methods. Every palette index and end flag is checked
// against a behavioral model of the error stores, with random stalls on both
// channels in the earlier phases.
// ----------------------------------------------------------------------------
module palette_error_diffusion_dither_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ped_pkg::*;

   localparam int CYCLE_LIMIT = 6000000;
   localparam int DRAIN_CYCLES = 1200;

   typedef struct {
      kind_type   kind;
      logic [7:0] entry;
      logic [7:0] chan [4];
   } dither_item_t;

   typedef struct {
      logic [7:0] index;
      logic       row_end;
      logic       image_end;
   } pixel_answer_t;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ped_req_if req_bus();
   ped_rsp_if rsp_bus();

   palette_error_diffusion_dither uut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   dither_item_t pending_items[$];
   pixel_answer_t expected_answers[$];
   int send_idle_pct;
   int recv_idle_pct;
   int mismatches;
   int cycles;
   bit accepted_now;

   logic [METHOD_W-1:0] cfg_method;
   int unsigned cfg_width, cfg_height, cfg_entries;
   logic [31:0] palette [PALETTE_DEPTH];
   int err_cur [MAX_WIDTH][4];
   int err_next [MAX_WIDTH][4];
   int err_after [MAX_WIDTH][4];
   int unsigned column_pos, row_pos;

   function automatic int weighted_share(int e, int num, int sh);
      int m, q;
      m = e < 0 ? -e : e;
      q = (m * num) >>> sh;
      return e < 0 ? -q : q;
   endfunction

   function automatic int clamp16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic void add_cur(int unsigned x, int e[4], int num, int sh);
      for (int c = 0; c < 4; c++)
         err_cur[x][c] = clamp16(err_cur[x][c] + weighted_share(e[c], num, sh));
   endfunction

   function automatic void add_next(int unsigned x, int e[4], int num, int sh);
      for (int c = 0; c < 4; c++)
         err_next[x][c] = clamp16(err_next[x][c] + weighted_share(e[c], num, sh));
   endfunction

   function automatic void add_after(int unsigned x, int e[4], int num, int sh);
      for (int c = 0; c < 4; c++)
         err_after[x][c] = clamp16(err_after[x][c] + weighted_share(e[c], num, sh));
   endfunction

   function automatic void clear_error_rows();
      for (int i = 0; i < MAX_WIDTH; i++)
         for (int c = 0; c < 4; c++) begin
            err_cur[i][c] = 0;
            err_next[i][c] = 0;
            err_after[i][c] = 0;
         end
   endfunction

   function automatic void dither_transfer(dither_item_t it);
      int unsigned w, h, n, x, best;
      int bestd, d, df, p;
      int colr[4], e[4];
      bit last_col, last_row;
      pixel_answer_t ans;
      if (it.kind == KIND_LOAD) begin
         palette[it.entry] = {it.chan[3], it.chan[2], it.chan[1], it.chan[0]};
         return;
      end
      w = cfg_width == 0 ? 1 : cfg_width;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      h = cfg_height == 0 ? 1 : cfg_height;
      n = cfg_entries == 0 ? 1 : cfg_entries;
      if (n > PALETTE_DEPTH) n = PALETTE_DEPTH;
      x = column_pos >= MAX_WIDTH ? MAX_WIDTH - 1 : column_pos;
      last_col = x + 1 >= w;
      last_row = row_pos + 1 >= h;
      for (int c = 0; c < 4; c++) begin
         colr[c] = (int'(it.chan[c]) << 4) + err_cur[x][c];
         if (colr[c] < 0) colr[c] = 0;
         if (colr[c] > 4080) colr[c] = 4080;
      end
      best = 0;
      bestd = -1;
      for (int unsigned i = 0; i < n; i++) begin
         d = 0;
         for (int c = 0; c < 4; c++) begin
            p = int'(palette[i][8*c +: 8]) << 4;
            df = colr[c] - p;
            d += df * df;
         end
         if (bestd < 0 || d < bestd) begin
            bestd = d;
            best = i;
         end
      end
      for (int c = 0; c < 4; c++)
         e[c] = colr[c] - (int'(palette[best][8*c +: 8]) << 4);
      if (cfg_method == METHOD_FLOYD) begin
         if (x + 1 < w) add_cur(x + 1, e, 7, 4);
         if (!last_row) begin
            if (x > 0) add_next(x - 1, e, 3, 4);
            add_next(x, e, 5, 4);
            if (x + 1 < w) add_next(x + 1, e, 1, 4);
         end
      end else if (cfg_method == METHOD_ATKINSON) begin
         if (x + 1 < w) begin
            add_cur(x + 1, e, 1, 3);
            if (x + 2 < w) add_cur(x + 2, e, 1, 3);
         end
         if (!last_row) begin
            if (x > 0) add_next(x - 1, e, 1, 3);
            add_next(x, e, 1, 3);
            if (x + 1 < w) add_next(x + 1, e, 1, 3);
            if (row_pos + 2 < h) add_after(x, e, 1, 3);
         end
      end
      ans.index = best[7:0];
      ans.row_end = last_col;
      ans.image_end = last_col && last_row;
      expected_answers.push_back(ans);
      if (last_col) begin
         column_pos = 0;
         if (last_row) begin
            row_pos = 0;
            clear_error_rows();
         end else begin
            row_pos = (row_pos + 1) & 16'hFFFF;
            err_cur = err_next;
            err_next = err_after;
            for (int i = 0; i < MAX_WIDTH; i++)
               for (int c = 0; c < 4; c++)
                  err_after[i][c] = 0;
         end
      end else begin
         column_pos = x + 1;
      end
   endfunction

   function automatic dither_item_t make_item(kind_type k, logic [7:0] ent, logic [31:0] rgba);
      dither_item_t it;
      it.kind = k;
      it.entry = ent;
      for (int c = 0; c < 4; c++) it.chan[c] = rgba[8*c +: 8];
      return it;
   endfunction

   function automatic logic [7:0] random_channel();
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic void queue_random(int pixels);
      dither_item_t it;
      int made;
      made = 0;
      while (made < pixels) begin
         it.kind = $urandom_range(0, 99) < 12 ? KIND_LOAD : KIND_PIXEL;
         it.entry = 8'($urandom_range(0, 255));
         for (int c = 0; c < 4; c++) it.chan[c] = random_channel();
         if (it.kind == KIND_PIXEL) made++;
         pending_items.push_back(it);
      end
   endfunction

   task automatic wait_idle();
      while (pending_items.size() != 0 || req_bus.valid || expected_answers.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int unsigned value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      case (idx)
         REG_METHOD: cfg_method = value[METHOD_W-1:0];
         REG_WIDTH: cfg_width = value & 32'h7FF;
         REG_HEIGHT: cfg_height = value & 32'hFFFF;
         REG_ENTRIES: cfg_entries = value & 32'h1FF;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(int unsigned method, int unsigned width, int unsigned height,
                            int unsigned entries, int pixels);
      wait_idle();
      write_reg(REG_METHOD, method);
      write_reg(REG_WIDTH, width);
      write_reg(REG_HEIGHT, height);
      write_reg(REG_ENTRIES, entries);
      queue_random(pixels);
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.operation = 1'b0;
      req_bus.entry_number = '0;
      req_bus.red = '0;
      req_bus.green = '0;
      req_bus.blue = '0;
      req_bus.alpha = '0;
      rsp_bus.ready = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      logic [31:0] twin;
      cfg_method = METHOD_FLOYD;
      cfg_width = 1024;
      cfg_height = 768;
      cfg_entries = 256;
      column_pos = 0;
      row_pos = 0;
      mismatches = 0;
      clear_error_rows();
      for (int i = 0; i < PALETTE_DEPTH; i++) palette[i] = '0;
      send_idle_pct = 34;
      recv_idle_pct = 80;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // The whole palette is loaded first so that no search reads an unwritten entry.
      twin = $urandom;
      for (int i = 0; i < PALETTE_DEPTH; i++) begin
         if (i == 0)
            pending_items.push_back(make_item(KIND_LOAD, 8'(i), 32'h0000_0000));
         else if (i == 1)
            pending_items.push_back(make_item(KIND_LOAD, 8'(i), 32'hFFFF_FFFF));
         else if (i == 5 || i == 9)
            pending_items.push_back(make_item(KIND_LOAD, 8'(i), twin));
         else
            pending_items.push_back(make_item(KIND_LOAD, 8'(i), $urandom));
      end
      pending_items.push_back(make_item(KIND_PIXEL, 8'h00, 32'h0000_0000));
      pending_items.push_back(make_item(KIND_PIXEL, 8'h00, 32'hFFFF_FFFF));
      pending_items.push_back(make_item(KIND_PIXEL, 8'h00, twin));
      pending_items.push_back(make_item(KIND_PIXEL, 8'h00, 32'hFF00_FF00));
      pending_items.push_back(make_item(KIND_PIXEL, 8'h00, 32'h00FF_00FF));
      pending_items.push_back(make_item(KIND_PIXEL, 8'h00, 32'h8080_8080));
      pending_items.push_back(make_item(KIND_PIXEL, 8'h00, 32'h7F7F_7F7F));
      pending_items.push_back(make_item(KIND_PIXEL, 8'h00, twin));
      pending_items.push_back(make_item(KIND_PIXEL, 8'h00, 32'h0102_0408));
      pending_items.push_back(make_item(KIND_PIXEL, 8'h00, 32'hFEFD_FBF7));
      pending_items.push_back(make_item(KIND_LOAD, 8'hFF, 32'h1234_5678));
      pending_items.push_back(make_item(KIND_PIXEL, 8'h00, 32'h1234_5678));

      run_phase(METHOD_FLOYD, 5, 4, 16, 300);
      run_phase(METHOD_ATKINSON, 7, 3, 16, 300);
      run_phase(METHOD_NONE, 3, 2, 8, 150);
      send_idle_pct = 80;
      recv_idle_pct = 34;
      run_phase(3, 1, 1, 4, 100);
      run_phase(METHOD_ATKINSON, 0, 0, 0, 60);
      run_phase(METHOD_FLOYD, 2047, 65535, 511, 30);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase(METHOD_FLOYD, 1024, 3, 6, 300);
      // The image is left unfinished so the counters start past the new, smaller size.
      run_phase(METHOD_ATKINSON, 4, 5, 16, 300);
      run_phase(METHOD_FLOYD, 6, 3, 32, 400);
      wait_idle();
      if (mismatches == 0 && expected_answers.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Transfers and checks are taken at the rising edge.
   always @(posedge clock) begin
      accepted_now = 1'b0;
      if (!reset) begin
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end else begin
            if (req_bus.valid && req_bus.ready) begin
               accepted_now = 1'b1;
               dither_transfer(make_item(kind_type'(req_bus.operation), req_bus.entry_number,
                  {req_bus.alpha, req_bus.blue, req_bus.green, req_bus.red}));
            end
            if (rsp_bus.valid && rsp_bus.ready) begin
               if (expected_answers.size() == 0) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Unexpected result transfer: index %0d", rsp_bus.chosen_index);
               end else begin
                  pixel_answer_t exp_ans;
                  exp_ans = expected_answers.pop_front();
                  if (rsp_bus.chosen_index !== exp_ans.index ||
                      rsp_bus.row_end !== exp_ans.row_end ||
                      rsp_bus.image_end !== exp_ans.image_end) begin
                     mismatches++;
                     if (mismatches <= 10)
                        $display({"Mismatch: expected index %0d row_end %0b ",
                                  "image_end %0b, got %0d %0b %0b"},
                           exp_ans.index, exp_ans.row_end, exp_ans.image_end,
                           rsp_bus.chosen_index, rsp_bus.row_end, rsp_bus.image_end);
                  end
               end
            end
         end
      end
   end

   // Inputs change at the falling edge.
   always @(negedge clock) begin
      dither_item_t it;
      if (reset) begin
         req_bus.valid <= 1'b0;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= $urandom_range(0, 99) >= recv_idle_pct;
         if (!req_bus.valid || accepted_now) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               it = pending_items.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.operation <= it.kind;
               req_bus.entry_number <= it.entry;
               req_bus.red <= it.chan[0];
               req_bus.green <= it.chan[1];
               req_bus.blue <= it.chan[2];
               req_bus.alpha <= it.chan[3];
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end
endmodule
